// ===== hw/rtl/itch_message_parser_core_macros.svh =====
// Assertion helpers shared by the parser RTL.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef ITCH_MESSAGE_PARSER_CORE_MACROS_SVH
`define ITCH_MESSAGE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define ITCHP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ITCHP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/itchp_pkg.sv =====
package itchp_pkg;

   // Payload bytes captured per frame; the longest fixed message is 40 bytes
   localparam int CAPTURE_DEPTH = 40;
   localparam int NUM_KINDS     = 9;
   localparam int STORE_BITS    = CAPTURE_DEPTH * 8;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK   = 3'd0,
      ST_EOF  = 3'd1,
      ST_LEN  = 3'd2,
      ST_SIDE = 3'd3,
      ST_TYPE = 3'd4
   } status_type;

   // Message kinds, in tag table order
   typedef enum logic [3:0] {
      KIND_S = 4'd0,
      KIND_R = 4'd1,
      KIND_A = 4'd2,
      KIND_F = 4'd3,
      KIND_E = 4'd4,
      KIND_C = 4'd5,
      KIND_X = 4'd6,
      KIND_D = 4'd7,
      KIND_U = 4'd8
   } kind_type;

   // Framing phase
   typedef enum logic [1:0] {
      PHASE_LEN_HI  = 2'd0,
      PHASE_LEN_LO  = 2'd1,
      PHASE_PAYLOAD = 2'd2
   } phase_type;

   localparam logic [7:0] CHAR_B = 8'h42;
   localparam logic [7:0] CHAR_S = 8'h53;
   localparam logic [7:0] CHAR_Y = 8'h59;

   localparam logic [7:0] KIND_TAG [NUM_KINDS] = '{
      8'h53, 8'h52, 8'h41, 8'h46, 8'h45, 8'h43, 8'h58, 8'h44, 8'h55
   };

   // Fixed payload size of each kind
   function automatic logic [15:0] kind_size(input logic [3:0] kind);
      logic [15:0] size;
      case (kind)
         KIND_S:  size = 16'd12;
         KIND_R:  size = 16'd39;
         KIND_A:  size = 16'd36;
         KIND_F:  size = 16'd40;
         KIND_E:  size = 16'd31;
         KIND_C:  size = 16'd36;
         KIND_X:  size = 16'd23;
         KIND_D:  size = 16'd19;
         KIND_U:  size = 16'd35;
         default: size = 16'd0;
      endcase
      return size;
   endfunction

   // Decoded fields of one message, frame length excluded
   typedef struct packed {
      status_type  status;
      logic [3:0]  msg_kind;
      logic [15:0] stock_locate;
      logic [15:0] tracking_number;
      logic [47:0] timestamp;
      logic [63:0] order_reference;
      logic        side_or_printable;
      logic [31:0] quantity;
      logic [31:0] price;
      logic [63:0] symbol_or_match;
      logic [31:0] event_or_attribution;
   } dec_result_type;

   // Controls broadcast to the capture cells
   typedef struct packed {
      logic start;   // frame payload begins: seed the write token
      logic shift;   // payload byte accepted: token holder captures, token moves on
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/itchp_cell.sv =====
module itchp_cell
   import itchp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          tok_seed,
   input  logic          tok_prev,
   input  logic [7:0]    data_in,
   output logic          tok_out,
   output logic [7:0]    data_out
);

   logic       tok_ff;
   logic       tok_in;
   logic [7:0] data_ff;

   // Write token: seeded at frame start, passed along on each payload byte
   always_comb begin
      tok_in = tok_ff;
      if (ctrl.start) begin
         tok_in = tok_seed;
      end else if (ctrl.shift) begin
         tok_in = tok_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   // Capture the byte while this cell holds the token
   always_ff @(posedge clock) begin
      if (ctrl.shift && tok_ff) begin
         data_ff <= data_in;
      end
   end

   assign tok_out  = tok_ff;
   assign data_out = data_ff;

endmodule

// ===== hw/rtl/itchp_decode.sv =====
module itchp_decode
   import itchp_pkg::*;
(
   input  logic [STORE_BITS-1:0] store,
   input  logic [15:0]           decl_len,
   output dec_result_type        result
);

   // Payload byte k sits at the top end for k = 0, so fields read big-endian
   function automatic logic [7:0] byte_at(input logic [STORE_BITS-1:0] s, input int k);
      return s[(CAPTURE_DEPTH - 1 - k) * 8 +: 8];
   endfunction

   function automatic logic [15:0] be16(input logic [STORE_BITS-1:0] s, input int at);
      return s[(CAPTURE_DEPTH - at - 2) * 8 +: 16];
   endfunction

   function automatic logic [31:0] be32(input logic [STORE_BITS-1:0] s, input int at);
      return s[(CAPTURE_DEPTH - at - 4) * 8 +: 32];
   endfunction

   function automatic logic [47:0] be48(input logic [STORE_BITS-1:0] s, input int at);
      return s[(CAPTURE_DEPTH - at - 6) * 8 +: 48];
   endfunction

   function automatic logic [63:0] be64(input logic [STORE_BITS-1:0] s, input int at);
      return s[(CAPTURE_DEPTH - at - 8) * 8 +: 64];
   endfunction

   logic [7:0] tag;
   logic [7:0] side;
   logic       hit;
   logic [3:0] kind_idx;

   assign tag  = byte_at(store, 0);
   assign side = byte_at(store, 19);

   // Tag lookup
   always_comb begin
      hit      = 1'b0;
      kind_idx = 4'd0;
      for (int k = 0; k < NUM_KINDS; k++) begin
         if (!hit && (tag == KIND_TAG[k])) begin
            hit      = 1'b1;
            kind_idx = 4'(k);
         end
      end
   end

   // Validation and field extraction
   always_comb begin
      result = '0;
      if (!hit) begin
         result.status = ST_TYPE;
      end else if (decl_len != kind_size(kind_idx)) begin
         result.status   = ST_LEN;
         result.msg_kind = kind_idx;
      end else if (((kind_idx == KIND_A) || (kind_idx == KIND_F)) &&
                   (side != CHAR_B) && (side != CHAR_S)) begin
         result.status   = ST_SIDE;
         result.msg_kind = kind_idx;
      end else begin
         result.status          = ST_OK;
         result.msg_kind        = kind_idx;
         result.stock_locate    = be16(store, 1);
         result.tracking_number = be16(store, 3);
         result.timestamp       = be48(store, 5);
         case (kind_idx)
            KIND_S: begin
               result.event_or_attribution = {24'd0, byte_at(store, 11)};
            end
            KIND_R: begin
               result.symbol_or_match = be64(store, 11);
               result.quantity        = be32(store, 21);
            end
            KIND_A, KIND_F: begin
               result.order_reference   = be64(store, 11);
               result.side_or_printable = (side == CHAR_S);
               result.quantity          = be32(store, 20);
               result.symbol_or_match   = be64(store, 24);
               result.price             = be32(store, 32);
               if (kind_idx == KIND_F) begin
                  result.event_or_attribution = be32(store, 36);
               end
            end
            KIND_E, KIND_C: begin
               result.order_reference = be64(store, 11);
               result.quantity        = be32(store, 19);
               result.symbol_or_match = be64(store, 23);
               if (kind_idx == KIND_C) begin
                  result.side_or_printable = (byte_at(store, 31) == CHAR_Y);
                  result.price             = be32(store, 32);
               end
            end
            KIND_X: begin
               result.order_reference = be64(store, 11);
               result.quantity        = be32(store, 19);
            end
            KIND_D: begin
               result.order_reference = be64(store, 11);
            end
            KIND_U: begin
               result.order_reference = be64(store, 11);
               result.symbol_or_match = be64(store, 19);
               result.quantity        = be32(store, 27);
               result.price           = be32(store, 31);
            end
            default: begin
               result = '0;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/itch_message_parser_core.sv =====
// Throughput: one stream byte per cycle while req_stall is low, including back-to-back frames.
// Response path: the edge that accepts the last byte of a frame captures it into the
// cell row and fills the decode stage, which loads the output register as it frees up.
// Input stalls only when decode stage and output register are full under rsp_stall.
// Reset (synchronous): returns to awaiting a length high byte, clears tokens and flags;
// captured payload bytes are not cleared.
module itch_message_parser_core
   import itchp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_msg_kind,
   output logic [15:0] rsp_stock_locate,
   output logic [15:0] rsp_tracking_number,
   output logic [47:0] rsp_timestamp,
   output logic [63:0] rsp_order_reference,
   output logic        rsp_side_or_printable,
   output logic [31:0] rsp_quantity,
   output logic [31:0] rsp_price,
   output logic [63:0] rsp_symbol_or_match,
   output logic [31:0] rsp_event_or_attribution,
   output logic [15:0] rsp_frame_length
);

`include "itch_message_parser_core_macros.svh"

   phase_type      phase_ff, phase_in;
   logic [15:0]    decl_len_ff;
   logic [15:0]    pay_count_ff;
   logic           halted_ff, halted_in;
   logic           pend_valid_ff, pend_valid_in;
   logic           pend_eof_ff;
   logic           pend_eos_ff;
   logic [15:0]    pend_flen_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   dec_result_type rsp_data_ff;
   logic [15:0]    rsp_flen_ff;

   logic           req_acc;
   logic           pend_adv;
   logic           halt_from_pend;
   logic           halt_eff;
   logic           byte_go;
   logic [15:0]    len_full;
   logic [15:0]    cnt_next;
   logic [16:0]    flen_wide;
   logic [15:0]    flen_sat;

   cell_ctrl_type  ctl;
   logic           produce;
   logic           prod_eof;
   logic [15:0]    prod_flen;
   logic           halt_eof;
   logic           produce_acc;

   logic [CAPTURE_DEPTH-1:0] tok_vec;
   logic [CAPTURE_DEPTH-1:0] tok_prev;
   logic [CAPTURE_DEPTH-1:0] tok_seed;
   logic [7:0]               cell_data [CAPTURE_DEPTH];
   logic [STORE_BITS-1:0]    store_flat;
   dec_result_type           dec;
   dec_result_type           eof_result;

   // Handshake: decode stage moves on when the output register is free or drains
   assign pend_adv  = pend_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pend_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_acc   = req_valid && !req_stall;

   // A decode error without end of stream halts the stream from the next byte on
   assign halt_from_pend = pend_valid_ff && !pend_eof_ff && (dec.status != ST_OK) &&
                           !pend_eos_ff;
   assign halt_eff       = halted_ff || halt_from_pend;
   assign byte_go        = req_acc && !halt_eff;

   assign len_full  = {decl_len_ff[15:8], req_data_byte};
   assign cnt_next  = pay_count_ff + 16'd1;
   assign flen_wide = {1'b0, cnt_next} + 17'd2;
   assign flen_sat  = flen_wide[16] ? 16'hFFFF : flen_wide[15:0];

   // Framing next state
   always_comb begin
      phase_in = phase_ff;
      if (req_acc) begin
         if (halt_eff) begin
            phase_in = PHASE_LEN_HI;
         end else begin
            case (phase_ff)
               PHASE_LEN_HI: begin
                  phase_in = req_end_of_stream ? PHASE_LEN_HI : PHASE_LEN_LO;
               end
               PHASE_LEN_LO: begin
                  if ((len_full != 16'd0) && !req_end_of_stream) begin
                     phase_in = PHASE_PAYLOAD;
                  end else begin
                     phase_in = PHASE_LEN_HI;
                  end
               end
               PHASE_PAYLOAD: begin
                  if ((cnt_next == decl_len_ff) || req_end_of_stream) begin
                     phase_in = PHASE_LEN_HI;
                  end
               end
               default: begin
                  phase_in = PHASE_LEN_HI;
               end
            endcase
         end
      end
   end

   // Framing outputs: cell controls and response production
   always_comb begin
      ctl       = '0;
      produce   = 1'b0;
      prod_eof  = 1'b0;
      prod_flen = 16'd0;
      halt_eof  = 1'b0;
      if (byte_go) begin
         case (phase_ff)
            PHASE_LEN_HI: begin
               if (req_end_of_stream) begin
                  produce   = 1'b1;
                  prod_eof  = 1'b1;
                  prod_flen = 16'd1;
               end
            end
            PHASE_LEN_LO: begin
               if ((len_full == 16'd0) || req_end_of_stream) begin
                  produce   = 1'b1;
                  prod_eof  = 1'b1;
                  prod_flen = 16'd2;
                  halt_eof  = !req_end_of_stream;
               end else begin
                  ctl.start = 1'b1;
               end
            end
            PHASE_PAYLOAD: begin
               ctl.shift = 1'b1;
               if (cnt_next == decl_len_ff) begin
                  produce   = 1'b1;
                  prod_flen = flen_sat;
               end else if (req_end_of_stream) begin
                  produce   = 1'b1;
                  prod_eof  = 1'b1;
                  prod_flen = flen_sat;
               end
            end
            default: begin
               produce = 1'b0;
            end
         endcase
      end
   end

   assign produce_acc = produce;

   // Halt flag
   always_comb begin
      if (req_acc) begin
         halted_in = halt_eff ? !req_end_of_stream : halt_eof;
      end else begin
         halted_in = halt_eff;
      end
   end

   assign pend_valid_in = produce_acc || (pend_valid_ff && !pend_adv);
   assign rsp_valid_in  = pend_adv || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_LEN_HI;
         decl_len_ff   <= 16'd0;
         pay_count_ff  <= 16'd0;
         halted_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         halted_ff     <= halted_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (byte_go) begin
            case (phase_ff)
               PHASE_LEN_HI: begin
                  decl_len_ff  <= {req_data_byte, 8'h00};
                  pay_count_ff <= 16'd0;
               end
               PHASE_LEN_LO: begin
                  decl_len_ff  <= len_full;
                  pay_count_ff <= 16'd0;
               end
               PHASE_PAYLOAD: begin
                  pay_count_ff <= cnt_next;
               end
               default: begin
                  pay_count_ff <= 16'd0;
               end
            endcase
         end
      end
   end

   // Decode stage payload
   always_ff @(posedge clock) begin
      if (produce_acc) begin
         pend_eof_ff  <= prod_eof;
         pend_eos_ff  <= req_end_of_stream;
         pend_flen_ff <= prod_flen;
      end
   end

   // Capture row: token passes cell to cell, holder takes the payload byte
   for (genvar i = 0; i < CAPTURE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign tok_prev[i] = 1'b0;
         assign tok_seed[i] = 1'b1;
      end else begin : g_body
         assign tok_prev[i] = tok_vec[i-1];
         assign tok_seed[i] = 1'b0;
      end

      itchp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctl),
         .tok_seed (tok_seed[i]),
         .tok_prev (tok_prev[i]),
         .data_in  (req_data_byte),
         .tok_out  (tok_vec[i]),
         .data_out (cell_data[i])
      );

      assign store_flat[(CAPTURE_DEPTH - 1 - i) * 8 +: 8] = cell_data[i];
   end

   itchp_decode u_decode (
      .store    (store_flat),
      .decl_len (decl_len_ff),
      .result   (dec)
   );

   // End-of-stream error response: everything zero but status
   always_comb begin
      eof_result        = '0;
      eof_result.status = ST_EOF;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (pend_adv) begin
         rsp_data_ff <= pend_eof_ff ? eof_result : dec;
         rsp_flen_ff <= pend_flen_ff;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = rsp_data_ff.status;
   assign rsp_msg_kind             = rsp_data_ff.msg_kind;
   assign rsp_stock_locate         = rsp_data_ff.stock_locate;
   assign rsp_tracking_number      = rsp_data_ff.tracking_number;
   assign rsp_timestamp            = rsp_data_ff.timestamp;
   assign rsp_order_reference      = rsp_data_ff.order_reference;
   assign rsp_side_or_printable    = rsp_data_ff.side_or_printable;
   assign rsp_quantity             = rsp_data_ff.quantity;
   assign rsp_price                = rsp_data_ff.price;
   assign rsp_symbol_or_match      = rsp_data_ff.symbol_or_match;
   assign rsp_event_or_attribution = rsp_data_ff.event_or_attribution;
   assign rsp_frame_length         = rsp_flen_ff;

   // Checks
   `ITCHP_ASSERT_IMP(a_token_onehot0, 1'b1, $onehot0(tok_vec), "write token duplicated")
   `ITCHP_ASSERT_IMP(a_count_below_len, phase_ff == PHASE_PAYLOAD,
                     pay_count_ff < decl_len_ff, "payload count reached length in payload")
   `ITCHP_ASSERT_IMP(a_halt_at_frame_edge, halted_ff, phase_ff == PHASE_LEN_HI,
                     "halted inside a frame")
   `ITCHP_ASSERT_IMP(a_ok_length, rsp_valid_ff && (rsp_status == ST_OK),
                     rsp_frame_length == kind_size(rsp_msg_kind) + 16'd2,
                     "ok response with wrong frame length")
   `ITCHP_ASSERT_NXT(a_error_halts, pend_adv && halt_from_pend && !req_acc, halted_ff,
                     "decode error did not halt the stream")

endmodule

// ===== sim/itch_message_parser_core_tb.sv =====
`timescale 1ns / 100ps

module itch_message_parser_core_tb;
   import itchp_pkg::*;

   // Fixed payload size of each kind, in kind order
   localparam logic [15:0] MSG_SIZE [NUM_KINDS] = '{
      16'd12, 16'd39, 16'd36, 16'd40, 16'd31, 16'd36, 16'd23, 16'd19, 16'd35
   };

   localparam logic [7:0] TAG_UNKNOWN = 8'h5A;
   localparam logic [7:0] SIDE_BAD    = 8'h51;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam int         ANY         = -1;   // byte left to the fill
   localparam int         NO_EOS      = -1;
   localparam int         RANDOM_BYTES = 620;
   localparam int         RANDOM_FRAMES = 16;

   typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_type;

   // One decoded message as seen on the response channel
   typedef struct packed {
      status_type  status;
      kind_type    kind;
      logic [15:0] locate;
      logic [15:0] tracking;
      logic [47:0] stamp;
      logic [63:0] order_ref;
      logic        side_prn;
      logic [31:0] quantity;
      logic [31:0] price;
      logic [63:0] sym_match;
      logic [31:0] event_attr;
      logic [15:0] frame_len;
   } msg_result_type;

   // One frame of stimulus; st/kind/flen are the typed-in response when pinned
   typedef struct packed {
      logic [7:0]  tag;
      logic [15:0] len;
      int          side;      // byte at payload offset 19, or ANY
      int          prn;       // byte at payload offset 31, or ANY
      int          eos_pos;   // frame byte carrying end of stream, or NO_EOS
      int          trail;     // junk bytes after the frame, last one ends the stream
      fill_type    fill;
      logic        pin;
      status_type  st;
      kind_type    kind;
      logic [15:0] flen;
   } frame_row_type;

   localparam int NUM_DIR = 20;
   localparam frame_row_type DIR_ROWS [NUM_DIR] = '{
      '{KIND_TAG[KIND_S], 16'd12, ANY,    ANY,    NO_EOS, 0, FILL_RAND, 1'b0, ST_OK,   KIND_S, 0},
      '{KIND_TAG[KIND_R], 16'd39, ANY,    ANY,    NO_EOS, 0, FILL_ZERO, 1'b0, ST_OK,   KIND_R, 0},
      '{KIND_TAG[KIND_A], 16'd36, CHAR_B, ANY,    NO_EOS, 0, FILL_RAND, 1'b0, ST_OK,   KIND_A, 0},
      '{KIND_TAG[KIND_F], 16'd40, CHAR_S, ANY,    NO_EOS, 0, FILL_ONES, 1'b0, ST_OK,   KIND_F, 0},
      '{KIND_TAG[KIND_E], 16'd31, ANY,    ANY,    NO_EOS, 0, FILL_RAND, 1'b0, ST_OK,   KIND_E, 0},
      '{KIND_TAG[KIND_C], 16'd36, ANY,    CHAR_Y, NO_EOS, 0, FILL_RAND, 1'b0, ST_OK,   KIND_C, 0},
      '{KIND_TAG[KIND_C], 16'd36, ANY,    CHAR_N, NO_EOS, 0, FILL_ONES, 1'b0, ST_OK,   KIND_C, 0},
      '{KIND_TAG[KIND_X], 16'd23, ANY,    ANY,    NO_EOS, 0, FILL_RAND, 1'b0, ST_OK,   KIND_X, 0},
      '{KIND_TAG[KIND_D], 16'd19, ANY,    ANY,    NO_EOS, 0, FILL_ZERO, 1'b0, ST_OK,   KIND_D, 0},
      '{KIND_TAG[KIND_U], 16'd35, ANY,    ANY,    NO_EOS, 0, FILL_ONES, 1'b0, ST_OK,   KIND_U, 0},
      // bad side on an add, then dropped bytes up to end of stream
      '{KIND_TAG[KIND_A], 16'd36, SIDE_BAD, ANY,  NO_EOS, 3, FILL_RAND, 1'b1, ST_SIDE, KIND_A, 38},
      // declared length off by one
      '{KIND_TAG[KIND_S], 16'd13, ANY,    ANY,    NO_EOS, 1, FILL_RAND, 1'b1, ST_LEN,  KIND_S, 15},
      '{TAG_UNKNOWN,      16'd12, ANY,    ANY,    NO_EOS, 2, FILL_RAND, 1'b1, ST_TYPE, KIND_S, 14},
      // zero length
      '{KIND_TAG[KIND_S], 16'd0,  ANY,    ANY,    NO_EOS, 2, FILL_RAND, 1'b1, ST_EOF,  KIND_S, 2},
      // stream ends on the high or low length byte
      '{KIND_TAG[KIND_S], 16'd12, ANY,    ANY,    0,      0, FILL_RAND, 1'b1, ST_EOF,  KIND_S, 1},
      '{KIND_TAG[KIND_S], 16'd12, ANY,    ANY,    1,      0, FILL_RAND, 1'b1, ST_EOF,  KIND_S, 2},
      // stream ends inside the payload
      '{KIND_TAG[KIND_A], 16'd36, CHAR_B, ANY,    10,     0, FILL_RAND, 1'b1, ST_EOF,  KIND_S, 11},
      // stream ends on the last payload byte: decoded normally
      '{KIND_TAG[KIND_D], 16'd19, ANY,    ANY,    20,     0, FILL_RAND, 1'b0, ST_OK,   KIND_D, 0},
      // payload longer than the capture depth
      '{KIND_TAG[KIND_A], 16'd41, CHAR_S, ANY,    NO_EOS, 1, FILL_RAND, 1'b1, ST_LEN,  KIND_A, 43},
      '{KIND_TAG[KIND_F], 16'd40, CHAR_B, ANY,    NO_EOS, 0, FILL_RAND, 1'b0, ST_OK,   KIND_F, 0}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_end_of_stream;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_msg_kind;
   logic [15:0] rsp_stock_locate;
   logic [15:0] rsp_tracking_number;
   logic [47:0] rsp_timestamp;
   logic [63:0] rsp_order_reference;
   logic        rsp_side_or_printable;
   logic [31:0] rsp_quantity;
   logic [31:0] rsp_price;
   logic [63:0] rsp_symbol_or_match;
   logic [31:0] rsp_event_or_attribution;
   logic [15:0] rsp_frame_length;

   // Stream tracker state
   phase_type   trk_phase;
   logic [15:0] trk_len;
   logic [15:0] trk_count;
   logic [7:0]  trk_store [CAPTURE_DEPTH];
   logic        trk_halted;

   msg_result_type pending_msgs [$];
   msg_result_type cur_want;
   logic           cur_pin;
   bit             idle_on;
   int             n_errors;
   int             n_checked;
   int             n_bytes;

   itch_message_parser_core DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Big-endian read of captured payload bytes
   function automatic logic [63:0] be_get(int at, int n);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++) v = {v[55:0], trk_store[at + i]};
      return v;
   endfunction

   // Advance the tracker by one stream byte; got is set when a response is due
   task automatic decode_stream_byte(input logic [7:0] b, input logic eos,
                                     output bit got, output msg_result_type res);
      logic [16:0] used;
      logic [15:0] flen;
      logic [7:0]  tag;
      logic [7:0]  side;
      status_type  st;
      kind_type    kd;
      int          k;
      got = 1'b0;
      res = '0;
      if (trk_halted) begin
         if (eos) begin
            trk_halted = 1'b0;
            trk_phase  = PHASE_LEN_HI;
         end
         return;
      end
      case (trk_phase)
         PHASE_LEN_HI: begin
            trk_len   = {b, 8'h00};
            trk_count = '0;
            trk_phase = PHASE_LEN_LO;
            if (!eos) return;
            res.status = ST_EOF;
            flen = 16'd1;
         end
         PHASE_LEN_LO: begin
            trk_len   = trk_len | {8'h00, b};
            trk_count = '0;
            if (trk_len != 16'd0 && !eos) begin
               trk_phase = PHASE_PAYLOAD;
               return;
            end
            res.status = ST_EOF;
            flen = 16'd2;
         end
         default: begin
            if (trk_count < CAPTURE_DEPTH) trk_store[trk_count] = b;
            trk_count = trk_count + 16'd1;
            if (trk_count == trk_len) begin
               // frame complete: classify, then pull fields
               tag = trk_store[0];
               k = NUM_KINDS;
               for (int i = NUM_KINDS - 1; i >= 0; i--) if (KIND_TAG[i] == tag) k = i;
               side = trk_store[19];
               if (k == NUM_KINDS) begin
                  res.status = ST_TYPE;
               end else begin
                  res.kind = kind_type'(k);
                  if (trk_len != MSG_SIZE[k]) begin
                     res.status = ST_LEN;
                  end else if ((res.kind == KIND_A || res.kind == KIND_F) &&
                               side != CHAR_B && side != CHAR_S) begin
                     res.status = ST_SIDE;
                  end else begin
                     res.status   = ST_OK;
                     res.locate   = 16'(be_get(1, 2));
                     res.tracking = 16'(be_get(3, 2));
                     res.stamp    = 48'(be_get(5, 6));
                     case (res.kind)
                        KIND_S: res.event_attr = {24'h0, trk_store[11]};
                        KIND_R: begin
                           res.sym_match = be_get(11, 8);
                           res.quantity  = 32'(be_get(21, 4));
                        end
                        KIND_A, KIND_F: begin
                           res.order_ref = be_get(11, 8);
                           res.side_prn  = (side == CHAR_S);
                           res.quantity  = 32'(be_get(20, 4));
                           res.sym_match = be_get(24, 8);
                           res.price     = 32'(be_get(32, 4));
                           if (res.kind == KIND_F) res.event_attr = 32'(be_get(36, 4));
                        end
                        KIND_E, KIND_C: begin
                           res.order_ref = be_get(11, 8);
                           res.quantity  = 32'(be_get(19, 4));
                           res.sym_match = be_get(23, 8);
                           if (res.kind == KIND_C) begin
                              res.side_prn = (trk_store[31] == CHAR_Y);
                              res.price    = 32'(be_get(32, 4));
                           end
                        end
                        KIND_X: begin
                           res.order_ref = be_get(11, 8);
                           res.quantity  = 32'(be_get(19, 4));
                        end
                        KIND_D: res.order_ref = be_get(11, 8);
                        default: begin
                           res.order_ref = be_get(11, 8);
                           res.sym_match = be_get(19, 8);
                           res.quantity  = 32'(be_get(27, 4));
                           res.price     = 32'(be_get(31, 4));
                        end
                     endcase
                  end
               end
            end else if (eos) begin
               res.status = ST_EOF;
            end else begin
               return;
            end
            used = 17'd2 + {1'b0, trk_count};
            flen = (used > 17'd65535) ? 16'hFFFF : used[15:0];
         end
      endcase
      // errors carry only status, kind and length, and halt unless the stream ended
      if (res.status != ST_OK) begin
         st  = res.status;
         kd  = res.kind;
         res = '0;
         res.status = st;
         res.kind   = (st == ST_EOF || st == ST_TYPE) ? KIND_S : kd;
         if (!eos) trk_halted = 1'b1;
      end
      res.frame_len = flen;
      trk_phase = PHASE_LEN_HI;
      got = 1'b1;
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      n_errors++;
   endtask

   task automatic compare_response(msg_result_type w);
      if (rsp_status !== w.status) report_mismatch("status", rsp_status, w.status);
      if (rsp_msg_kind !== w.kind) report_mismatch("msg_kind", rsp_msg_kind, w.kind);
      if (rsp_stock_locate !== w.locate)
         report_mismatch("stock_locate", rsp_stock_locate, w.locate);
      if (rsp_tracking_number !== w.tracking)
         report_mismatch("tracking_number", rsp_tracking_number, w.tracking);
      if (rsp_timestamp !== w.stamp) report_mismatch("timestamp", rsp_timestamp, w.stamp);
      if (rsp_order_reference !== w.order_ref)
         report_mismatch("order_reference", rsp_order_reference, w.order_ref);
      if (rsp_side_or_printable !== w.side_prn)
         report_mismatch("side_or_printable", rsp_side_or_printable, w.side_prn);
      if (rsp_quantity !== w.quantity) report_mismatch("quantity", rsp_quantity, w.quantity);
      if (rsp_price !== w.price) report_mismatch("price", rsp_price, w.price);
      if (rsp_symbol_or_match !== w.sym_match)
         report_mismatch("symbol_or_match", rsp_symbol_or_match, w.sym_match);
      if (rsp_event_or_attribution !== w.event_attr)
         report_mismatch("event_or_attribution", rsp_event_or_attribution, w.event_attr);
      if (rsp_frame_length !== w.frame_len)
         report_mismatch("frame_length", rsp_frame_length, w.frame_len);
   endtask

   // Offer one byte, after a random gap when idle_on is set, and hold it until accepted
   task automatic send_byte(logic [7:0] b, logic eos, logic pin, msg_result_type want);
      int gap;
      gap = idle_on ? $urandom_range(0, 12) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_data_byte     = b;
      req_end_of_stream = eos;
      cur_pin           = pin;
      cur_want          = want;
      req_valid         = 1'b1;
      do @(posedge clock); while (req_stall);
      n_bytes++;
   endtask

   // Emit one frame, then any trailing junk that ends the stream
   task automatic send_frame(frame_row_type r);
      int             nb;
      int             p;
      logic [7:0]     b;
      msg_result_type want;
      want = '0;
      want.status    = r.st;
      want.kind      = r.kind;
      want.frame_len = r.flen;
      nb = (r.eos_pos >= 0) ? r.eos_pos + 1 : 2 + r.len;
      for (int i = 0; i < nb; i++) begin
         if (i == 0) begin
            b = r.len[15:8];
         end else if (i == 1) begin
            b = r.len[7:0];
         end else begin
            p = i - 2;
            case (r.fill)
               FILL_ZERO: b = 8'h00;
               FILL_ONES: b = 8'hFF;
               default:   b = 8'($urandom_range(0, 255));
            endcase
            if (p == 0) b = r.tag;
            else if (p == 19 && r.side >= 0) b = r.side[7:0];
            else if (p == 31 && r.prn >= 0) b = r.prn[7:0];
         end
         send_byte(b, i == r.eos_pos, r.pin && (i == nb - 1), want);
      end
      for (int t = 0; t < r.trail; t++)
         send_byte(8'($urandom_range(0, 255)), t == r.trail - 1, 1'b0, want);
   endtask

   // Response side: random stall before each response when idle_on is set
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         n = idle_on ? $urandom_range(0, 12) : 0;
         repeat (n) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Check responses, then track accepted requests
   always @(posedge clock) begin : watch
      bit             got;
      msg_result_type pred;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_msgs.size() == 0) begin
               report_mismatch("response with nothing pending", 0, 0);
            end else begin
               compare_response(pending_msgs.pop_front());
               n_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            decode_stream_byte(req_data_byte, req_end_of_stream, got, pred);
            if (cur_pin) begin
               if (!got) report_mismatch("pinned request gave no response", 0, 1);
               pred = cur_want;
            end
            if (got) pending_msgs = {pending_msgs, pred};
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      frame_row_type r;
      int            k;
      int            sel;
      int            n_rand;
      int            rand_start;
      req_valid         = 1'b0;
      req_data_byte     = 8'h00;
      req_end_of_stream = 1'b0;
      cur_pin           = 1'b0;
      cur_want          = '0;
      idle_on           = 1'b1;
      n_errors  = 0;
      n_checked = 0;
      n_bytes   = 0;
      n_rand    = 0;
      trk_phase  = PHASE_LEN_HI;
      trk_len    = '0;
      trk_count  = '0;
      trk_halted = 1'b0;
      foreach (trk_store[i]) trk_store[i] = 8'h00;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed frames
      for (int i = 0; i < NUM_DIR; i++) send_frame(DIR_ROWS[i]);

      // hold off until everything has drained
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_msgs.size() != 0) @(posedge clock);

      // random frames: mostly well formed, some broken ones followed by a resync
      rand_start = n_bytes;
      while (n_bytes - rand_start < RANDOM_BYTES || n_rand < RANDOM_FRAMES) begin
         idle_on = ($urandom_range(0, 4) != 0);
         k   = $urandom_range(0, NUM_KINDS - 1);
         sel = $urandom_range(0, 99);
         r = '0;
         r.tag     = KIND_TAG[k];
         r.len     = MSG_SIZE[k];
         r.side    = ANY;
         r.prn     = ANY;
         r.eos_pos = NO_EOS;
         r.trail   = 0;
         r.pin     = 1'b0;
         r.fill    = ($urandom_range(0, 19) == 0) ?
                     fill_type'($urandom_range(1, 2)) : FILL_RAND;
         if (sel < 70) begin
            if (k == KIND_A || k == KIND_F) r.side = $urandom_range(0, 1) ? CHAR_B : CHAR_S;
            if (k == KIND_C && $urandom_range(0, 1)) r.prn = CHAR_Y;
            if ($urandom_range(0, 9) == 0) r.eos_pos = r.len + 1;
         end else if (sel < 80) begin
            r.tag   = $urandom_range(0, 1) ? KIND_TAG[KIND_A] : KIND_TAG[KIND_F];
            r.len   = (r.tag == KIND_TAG[KIND_A]) ? MSG_SIZE[KIND_A] : MSG_SIZE[KIND_F];
            r.trail = $urandom_range(1, 4);
         end else if (sel < 88) begin
            r.len   = 16'($urandom_range(0, 45));
            r.trail = $urandom_range(1, 4);
         end else if (sel < 94) begin
            r.tag   = 8'($urandom_range(0, 255));
            r.len   = 16'($urandom_range(1, 45));
            r.trail = $urandom_range(1, 4);
         end else begin
            r.eos_pos = $urandom_range(0, r.len);
         end
         send_frame(r);
         n_rand++;
      end
      idle_on = 1'b1;

      // drain before the summary
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_msgs.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Ran %0d directed and %0d random frames, %0d bytes in all",
               NUM_DIR, n_rand, n_bytes);
      $display("Checked %0d responses, %0d mismatches", n_checked, n_errors);
      if (n_errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/itchp_pkg.sv
hw/rtl/itchp_cell.sv
hw/rtl/itchp_decode.sv
hw/rtl/itch_message_parser_core.sv
sim/itch_message_parser_core_tb.sv
